/* rtl/i2c_register_read_master_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the I2C register read master.
// Checks are compiled for simulation and drop out for synthesis.
// ---------------------------------------------------------------------------
`ifndef I2C_REGISTER_READ_MASTER_UNIT_MACROS_SVH
`define I2C_REGISTER_READ_MASTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is held off while reset is high.
`define I2CRR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i2crr assertion failed");

// Clocked check that also holds during reset.
`define I2CRR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("i2crr assertion failed");

`else

`define I2CRR_ASSERT(label, clk, rst, prop)
`define I2CRR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/i2crr_pkg.sv */
// ---------------------------------------------------------------------------
// i2crr_pkg
// Shared types and phase constants of the I2C register read master.
// ---------------------------------------------------------------------------
package i2crr_pkg;

  localparam int unsigned PhaseW = 7;

  // Phase numbers of the bus sequence.
  localparam logic [PhaseW-1:0] ST_IDLE     = 7'd0;
  localparam logic [PhaseW-1:0] ST_START_A  = 7'd1;
  localparam logic [PhaseW-1:0] ST_SEND_W   = 7'd3;
  localparam logic [PhaseW-1:0] ST_ACK_W    = 7'd19;
  localparam logic [PhaseW-1:0] ST_SEND_R   = 7'd22;
  localparam logic [PhaseW-1:0] ST_ACK_R    = 7'd38;
  localparam logic [PhaseW-1:0] ST_STOP_MID = 7'd41;
  localparam logic [PhaseW-1:0] ST_START_B  = 7'd42;
  localparam logic [PhaseW-1:0] ST_SEND_RD  = 7'd44;
  localparam logic [PhaseW-1:0] ST_ACK_RD   = 7'd60;
  localparam logic [PhaseW-1:0] ST_RECV     = 7'd63;
  localparam logic [PhaseW-1:0] ST_STOP_END = 7'd79;
  localparam logic [PhaseW-1:0] ST_DONE     = 7'd80;

  // Request kinds.
  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [6:0] SLAVE_ADDR_RESET = 7'd72;

  typedef struct packed {
    logic       req_type;
    logic [7:0] reg_addr;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [2:0] ack_missing;
  } res_t;

endpackage

/* rtl/i2crr_seq.sv */
// ---------------------------------------------------------------------------
// i2crr_seq
// Bus sequencer: holds the line state and steps it by one word per advance.
// ---------------------------------------------------------------------------
`include "i2c_register_read_master_unit_macros.svh"

module i2crr_seq
  import i2crr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic       adv,
  input  req_t       item,
  output res_t       res
);

  logic [6:0]        slave_addr;
  logic [PhaseW-1:0] phase, phase_next;
  logic [7:0]        shift, shift_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic [2:0]        ack, ack_next;
  logic [7:0]        target, target_next;
  logic              done;
  logic [7:0]        data;

  // Next state and result for the word in the input register.
  always_comb begin : step
    logic              is_send;
    logic              is_ack;
    logic [PhaseW-1:0] base;
    logic [PhaseW-1:0] off;
    logic [7:0]        byte_val;
    logic [2:0]        flag;
    logic [7:0]        sh;

    phase_next  = phase;
    shift_next  = shift;
    scl_next    = scl;
    sda_next    = sda;
    ack_next    = ack;
    target_next = target;
    done        = 1'b0;
    data        = 8'd0;
    is_send     = 1'b0;
    is_ack      = 1'b0;
    base        = ST_IDLE;
    byte_val    = 8'd0;
    flag        = 3'd0;

    // Decode which byte or ack slot the phase sits in.
    if (phase >= ST_SEND_W && phase < ST_ACK_W) begin
      is_send  = 1'b1;
      base     = ST_SEND_W;
      byte_val = {slave_addr, 1'b0};
    end else if (phase >= ST_ACK_W && phase < ST_SEND_R) begin
      is_ack = 1'b1;
      base   = ST_ACK_W;
      flag   = 3'b001;
    end else if (phase >= ST_SEND_R && phase < ST_ACK_R) begin
      is_send  = 1'b1;
      base     = ST_SEND_R;
      byte_val = target;
    end else if (phase >= ST_ACK_R && phase < ST_STOP_MID) begin
      is_ack = 1'b1;
      base   = ST_ACK_R;
      flag   = 3'b010;
    end else if (phase >= ST_SEND_RD && phase < ST_ACK_RD) begin
      is_send  = 1'b1;
      base     = ST_SEND_RD;
      byte_val = {slave_addr, 1'b1};
    end else if (phase >= ST_ACK_RD && phase < ST_RECV) begin
      is_ack = 1'b1;
      base   = ST_ACK_RD;
      flag   = 3'b100;
    end else if (phase >= ST_RECV && phase < ST_STOP_END) begin
      base = ST_RECV;
    end
    off = phase - base;
    sh  = (off[3:0] == 4'd0) ? byte_val : shift;

    if (item.req_type == REQ_BEGIN) begin
      // A begin arms the sequence only when idle.
      if (phase == ST_IDLE) begin
        target_next = item.reg_addr;
        ack_next    = 3'd0;
        phase_next  = ST_START_A;
      end
    end else if (phase != ST_IDLE) begin
      if (phase == ST_START_A || phase == ST_START_B) begin
        scl_next   = 1'b1;
        sda_next   = 1'b1;
        phase_next = phase + 7'd1;
      end else if (phase == ST_START_A + 7'd1 || phase == ST_START_B + 7'd1) begin
        scl_next   = 1'b1;
        sda_next   = 1'b0;
        phase_next = phase + 7'd1;
      end else if (is_send) begin
        // Data changes with SCL low, then SCL rises and the byte shifts.
        scl_next   = off[0];
        sda_next   = sh[7];
        shift_next = off[0] ? {sh[6:0], 1'b0} : sh;
        phase_next = phase + 7'd1;
      end else if (is_ack) begin
        if (off[1:0] == 2'd0) begin
          scl_next   = 1'b0;
          sda_next   = 1'b1;
          phase_next = base + 7'd1;
        end else if (off[1:0] == 2'd1) begin
          scl_next = 1'b1;
          sda_next = 1'b1;
          if (item.sda_in) begin
            ack_next   = ack | flag;
            phase_next = base + 7'd2;
          end else begin
            phase_next = base + 7'd3;
          end
        end else begin
          // Stop interval inserted after a missing ack.
          scl_next   = 1'b1;
          sda_next   = 1'b0;
          phase_next = base + 7'd3;
        end
      end else if (phase == ST_STOP_MID) begin
        scl_next   = 1'b1;
        sda_next   = 1'b0;
        phase_next = ST_START_B;
      end else if (phase >= ST_RECV && phase < ST_STOP_END) begin
        // Sample with SCL high, then pull SCL low.
        sda_next = 1'b1;
        if (!off[0]) begin
          scl_next   = 1'b1;
          shift_next = {shift[6:0], item.sda_in};
        end else begin
          scl_next = 1'b0;
        end
        phase_next = phase + 7'd1;
      end else if (phase == ST_STOP_END) begin
        scl_next   = 1'b1;
        sda_next   = 1'b0;
        phase_next = ST_DONE;
      end else begin
        scl_next   = 1'b1;
        sda_next   = 1'b1;
        phase_next = ST_IDLE;
        done       = 1'b1;
        data       = shift;
      end
    end
  end

  assign res.scl_level   = scl_next;
  assign res.sda_level   = sda_next;
  assign res.busy_res    = (phase_next != ST_IDLE);
  assign res.done_res    = done;
  assign res.read_data   = data;
  assign res.ack_missing = ack_next;

  // Sequencer state and the address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr <= SLAVE_ADDR_RESET;
      phase      <= ST_IDLE;
      shift      <= 8'd0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      ack        <= 3'd0;
      target     <= 8'd0;
    end else begin
      if (cfg_we) begin
        slave_addr <= cfg_data;
      end
      if (adv) begin
        phase  <= phase_next;
        shift  <= shift_next;
        scl    <= scl_next;
        sda    <= sda_next;
        ack    <= ack_next;
        target <= target_next;
      end
    end
  end

  // A finished read leaves the sequencer idle.
  `I2CRR_ASSERT(a_done_idle, clk, rst, (adv && res.done_res) |=> (phase == ST_IDLE))
  // The busy flag of a result matches the phase that follows it.
  `I2CRR_ASSERT(a_busy_phase, clk, rst, adv |=> ((phase != ST_IDLE) == $past(res.busy_res)))
  // SCL is only held low in the middle of a transaction.
  `I2CRR_ASSERT(a_scl_low_busy, clk, rst, (!scl) |-> (phase != ST_IDLE))
  // Reset leaves both lines released.
  `I2CRR_ASSERT_ALWAYS(a_reset_lines, clk, rst |=> (scl && sda && phase == ST_IDLE))

endmodule

/* rtl/i2c_register_read_master_unit.sv */
// ---------------------------------------------------------------------------
// i2c_register_read_master_unit
// I2C master reading one register of a slave, one bus interval per tick word.
// ---------------------------------------------------------------------------
// Usage: the request channel (req_valid, req_ready, req_word) takes begin
// words, which arm a read of reg_addr, and tick words, each of which moves the
// bus on by one interval and carries the sampled SDA level. Every request word
// gives exactly one result word on the result channel (res_valid, res_ready,
// res_word) with the SCL and SDA levels, busy, done, the received byte on the
// done word, and the missing-ack flags. A full read takes 77 ticks after begin
// when every ack is given, and one more tick for each missing ack.
// cfg_we with cfg_data writes the seven-bit slave address; write it only while
// no word is in flight.
// From acceptance, a word waits in the request register, then the sequencer
// step writes its result to the result register. One word is taken per cycle
// while the receiver takes results; the sequencer step is combinational.
// When the receiver stalls, the result register holds its word and the
// request register fills, after which req_ready drops until res_ready returns.
// Reset empties both registers, idles the sequencer, releases SCL and SDA and
// loads the slave address 72.
// ---------------------------------------------------------------------------
module i2c_register_read_master_unit
  import i2crr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req_word,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res_word,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  logic req_full;
  req_t req_hold;
  logic res_full;
  res_t res_hold;
  res_t step_res;
  logic adv;

  // The sequencer steps when a word waits and the result slot is free or being read out.
  assign adv       = req_full && (!res_full || res_ready);
  assign req_ready = !req_full || adv;
  assign res_valid = res_full;
  assign res_word  = res_hold;

  i2crr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .adv      (adv),
    .item     (req_hold),
    .res      (step_res)
  );

  // Request and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        req_full <= 1'b1;
      end else if (adv) begin
        req_full <= 1'b0;
      end
      if (adv) begin
        res_full <= 1'b1;
      end else if (res_ready) begin
        res_full <= 1'b0;
      end
    end
    if (req_valid && req_ready) begin
      req_hold <= req_word;
    end
    if (adv) begin
      res_hold <= step_res;
    end
  end

endmodule
